// ----- rtl/mrg_pkg.sv -----
// ----------------------------------------------------------------------------
// mrg_pkg
// Shared types and constants of the maze row generator.
// ----------------------------------------------------------------------------
package mrg_pkg;

	localparam int MAX_COLS_DEF = 32;
	localparam int MAX_ROWS     = 1024;

	localparam int ROW_W        = 10;
	localparam int WALL_W       = 32;
	localparam int RCOIN_W      = 31;
	localparam int BCOIN_W      = 32;
	localparam int ROWS_REG_W   = 11;
	localparam int COLS_REG_W   = 6;
	localparam int CFG_DATA_W   = 11;
	localparam int CFG_IDX_W    = 1;

	localparam logic [ROWS_REG_W-1:0] ROWS_RESET = 11'd10;
	localparam logic [COLS_REG_W-1:0] COLS_RESET = 6'd10;

	// Configuration register indexes.
	localparam logic [CFG_IDX_W-1:0] REG_MAZE_ROWS = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAZE_COLS = 1'b1;

	typedef struct packed {
		logic [RCOIN_W-1:0] right_coins;
		logic [BCOIN_W-1:0] bottom_coins;
	} mrg_coin_t;

	typedef struct packed {
		logic [ROW_W-1:0]  row_number;
		logic [WALL_W-1:0] right_walls;
		logic [WALL_W-1:0] bottom_walls;
		logic              last_row;
	} mrg_row_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RIGHT,
		ST_OPEN,
		ST_BOTTOM,
		ST_FINISH
	} mrg_state_t;

	typedef struct packed {
		logic load;
		logic step_right;
		logic step_open;
		logic step_bottom;
		logic clr_col;
		logic finish;
	} mrg_cmd_t;

	typedef struct packed {
		logic multi;
		logic right_end;
		logic bottom_end;
		logic is_last;
		logic out_busy;
	} mrg_status_t;

endpackage

// ----- rtl/mrg_ctrl.sv -----
// ----------------------------------------------------------------------------
// mrg_ctrl
// Sequencer of the row passes: right walls, last-row opening, bottom walls.
// ----------------------------------------------------------------------------
module mrg_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                coin_valid,
	output logic                coin_ready,
	input  mrg_pkg::mrg_status_t st,
	output mrg_pkg::mrg_cmd_t    cmd
);
	import mrg_pkg::*;

	mrg_state_t state_q;
	mrg_state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (coin_valid) begin
					state_d = ST_RIGHT;
				end
			end
			ST_RIGHT: begin
				if (!st.multi || st.right_end) begin
					state_d = st.is_last ? ST_OPEN : ST_BOTTOM;
				end
			end
			ST_OPEN: begin
				if (!st.multi || st.right_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_BOTTOM: begin
				if (st.bottom_end) begin
					state_d = ST_FINISH;
				end
			end
			ST_FINISH: begin
				if (!st.out_busy) begin
					state_d = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd        = '0;
		coin_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				coin_ready = 1'b1;
				cmd.load   = coin_valid;
			end
			ST_RIGHT: begin
				cmd.step_right = st.multi;
				cmd.clr_col    = !st.multi || st.right_end;
			end
			ST_OPEN: begin
				cmd.step_open = st.multi;
				cmd.clr_col   = !st.multi || st.right_end;
			end
			ST_BOTTOM: begin
				cmd.step_bottom = 1'b1;
				cmd.clr_col     = st.bottom_end;
			end
			ST_FINISH: begin
				cmd.finish = !st.out_busy;
			end
			default: cmd = '0;
		endcase
	end

endmodule

// ----- rtl/mrg_datapath.sv -----
// ----------------------------------------------------------------------------
// mrg_datapath
// Set labels, wall vectors, row counter, configuration and result register.
// ----------------------------------------------------------------------------
module mrg_datapath #(
	parameter int MAX_COLS = mrg_pkg::MAX_COLS_DEF
) (
	input  logic                             clk,
	input  logic                             arst_n,
	input  mrg_pkg::mrg_cmd_t                cmd,
	output mrg_pkg::mrg_status_t             st,
	input  mrg_pkg::mrg_coin_t               coin,
	input  logic                             cfg_we,
	input  logic [mrg_pkg::CFG_IDX_W-1:0]    cfg_addr,
	input  logic [mrg_pkg::CFG_DATA_W-1:0]   cfg_wdata,
	output logic                             row_valid,
	input  logic                             row_ready,
	output mrg_pkg::mrg_row_t                row
);
	import mrg_pkg::*;

	localparam int IW = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
	localparam int CW = $clog2(MAX_COLS + 1);

	logic [ROWS_REG_W-1:0] rows_q;
	logic [COLS_REG_W-1:0] cols_q;
	logic [ROWS_REG_W-1:0] rows_eff;
	logic [CW-1:0]         cols_eff;

	logic [IW-1:0]       col_q;
	logic [IW-1:0]       col_nb;
	logic [IW-1:0]       lbl_q [MAX_COLS];
	logic [IW-1:0]       nxt_lbl_q [MAX_COLS];
	logic [MAX_COLS-1:0] rcoin_q;
	logic [MAX_COLS-1:0] bcoin_q;
	logic [MAX_COLS-1:0] right_q;
	logic [MAX_COLS-1:0] bot_q;
	logic                last_q;
	logic [ROW_W-1:0]    row_q;
	mrg_row_t            out_q;
	logic                out_valid_q;

	logic [WALL_W-1:0]   rc_ext;
	logic [IW-1:0]       cur_lbl;
	logic [IW-1:0]       nb_lbl;
	logic [MAX_COLS-1:0] match;
	logic [MAX_COLS-1:0] nb_match;
	logic [MAX_COLS-1:0] cur_bit;
	logic [MAX_COLS-1:0] openm;
	logic [MAX_COLS-1:0] full_mask;
	logic [MAX_COLS-1:0] edge_mask;
	logic [IW-1:0]       first_idx;
	logic                r_wall;
	logic                b_wall;
	logic                open_join;
	logic                join_en;
	logic                step_any;

	// Out-of-range sizes are clamped into the supported range.
	always_comb begin
		if (rows_q == '0) begin
			rows_eff = ROWS_REG_W'(1);
		end else if (rows_q > ROWS_REG_W'(MAX_ROWS)) begin
			rows_eff = ROWS_REG_W'(MAX_ROWS);
		end else begin
			rows_eff = rows_q;
		end
		if (cols_q == '0) begin
			cols_eff = CW'(1);
		end else if (cols_q > COLS_REG_W'(MAX_COLS)) begin
			cols_eff = CW'(MAX_COLS);
		end else begin
			cols_eff = CW'(cols_q);
		end
	end

	assign col_nb  = (col_q == IW'(MAX_COLS - 1)) ? col_q : col_q + IW'(1);
	assign cur_lbl = lbl_q[col_q];
	assign nb_lbl  = lbl_q[col_nb];

	always_comb begin
		for (int j = 0; j < MAX_COLS; j++) begin
			match[j]     = (lbl_q[j] == cur_lbl);
			nb_match[j]  = (lbl_q[j] == nb_lbl);
			cur_bit[j]   = (IW'(j) == col_q);
			full_mask[j] = (CW'(j) < cols_eff);
			edge_mask[j] = (CW'(j + 1) == cols_eff);
		end
	end

	// Cells of the current set that are still open below; the current cell is
	// always among them, so the lowest one is the set's canonical label.
	assign openm = match & ~bot_q;

	always_comb begin
		first_idx = col_q;
		for (int j = MAX_COLS - 1; j >= 0; j--) begin
			if (openm[j]) begin
				first_idx = IW'(j);
			end
		end
	end

	assign r_wall    = rcoin_q[col_q] | (cur_lbl == nb_lbl);
	assign b_wall    = bcoin_q[col_q] & (|(openm & ~cur_bit));
	assign open_join = right_q[col_q] & (cur_lbl != nb_lbl);
	assign join_en   = (cmd.step_right & ~r_wall) | (cmd.step_open & open_join);
	assign step_any  = cmd.step_right | cmd.step_open | cmd.step_bottom;

	assign st.multi      = (cols_eff > CW'(1));
	assign st.right_end  = ((CW + 1)'(col_q) + (CW + 1)'(2)) == (CW + 1)'(cols_eff);
	assign st.bottom_end = ((CW + 1)'(col_q) + (CW + 1)'(1)) == (CW + 1)'(cols_eff);
	assign st.is_last    = last_q;
	assign st.out_busy   = out_valid_q & ~row_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rows_q <= ROWS_RESET;
			cols_q <= COLS_RESET;
		end else if (cfg_we) begin
			case (cfg_addr)
				REG_MAZE_ROWS: rows_q <= cfg_wdata;
				REG_MAZE_COLS: cols_q <= cfg_wdata[COLS_REG_W-1:0];
				default: ;
			endcase
		end
	end

	// A configuration write or a finished maze starts over with every cell in
	// a set of its own.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int j = 0; j < MAX_COLS; j++) begin
				lbl_q[j] <= IW'(j);
			end
			row_q <= '0;
		end else if (cfg_we) begin
			for (int j = 0; j < MAX_COLS; j++) begin
				lbl_q[j] <= IW'(j);
			end
			row_q <= '0;
		end else if (join_en) begin
			for (int j = 0; j < MAX_COLS; j++) begin
				if (nb_match[j]) begin
					lbl_q[j] <= cur_lbl;
				end
			end
		end else if (cmd.finish) begin
			for (int j = 0; j < MAX_COLS; j++) begin
				lbl_q[j] <= (full_mask[j] && !last_q) ? nxt_lbl_q[j] : IW'(j);
			end
			row_q <= last_q ? '0 : row_q + ROW_W'(1);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
		end else if (cmd.load || cmd.clr_col) begin
			col_q <= '0;
		end else if (step_any) begin
			col_q <= col_q + IW'(1);
		end
	end

	assign rc_ext = {1'b0, coin.right_coins};

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			rcoin_q <= rc_ext[MAX_COLS-1:0];
			bcoin_q <= coin.bottom_coins[MAX_COLS-1:0];
			right_q <= '0;
			bot_q   <= '0;
			last_q  <= (ROWS_REG_W'(row_q) + ROWS_REG_W'(1)) >= rows_eff;
		end else begin
			if (cmd.step_right) begin
				right_q[col_q] <= r_wall;
			end
			if (cmd.step_open && open_join) begin
				right_q[col_q] <= 1'b0;
			end
			if (cmd.step_bottom) begin
				bot_q[col_q]     <= b_wall;
				nxt_lbl_q[col_q] <= b_wall ? col_q : first_idx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.finish) begin
			out_valid_q <= 1'b1;
		end else if (row_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.finish) begin
			out_q.row_number   <= row_q;
			out_q.right_walls  <= WALL_W'(right_q | edge_mask);
			out_q.bottom_walls <= WALL_W'(last_q ? full_mask : bot_q);
			out_q.last_row     <= last_q;
		end
	end

	assign row_valid = out_valid_q;
	assign row       = out_q;

endmodule

// ----- rtl/maze_row_generator.sv -----
// ----------------------------------------------------------------------------
// maze_row_generator
// Eller's maze generator: one row of right and bottom walls per coin item.
// ----------------------------------------------------------------------------
//  channel   direction  signals                          payload
//  coin      in         coin_valid / coin_ready          right_coins, bottom_coins
//  row       out        row_valid / row_ready            row_number, walls, last_row
//  cfg       in         cfg_we, cfg_addr                 cfg_wdata (maze_rows, maze_cols)
//
// An item runs from its acceptance through the right-wall pass, then the opening
// pass on the last row or the bottom-wall pass on the others, and a finish step
// before the next input slot is free; a one-column maze still runs each of them.
// The passes run one column a cycle over the shared label compare row.
// Reset gives a 10 x 10 maze starting at row 0; a configuration write restarts
// the maze. A finished row waits in the output register while the next item
// is taken; it stalls only the final write-back of the following row.
module maze_row_generator #(
	parameter int MAX_COLS = mrg_pkg::MAX_COLS_DEF
) (
	input  logic                           clk,
	input  logic                           arst_n,
	input  logic                           coin_valid,
	output logic                           coin_ready,
	input  mrg_pkg::mrg_coin_t             coin,
	output logic                           row_valid,
	input  logic                           row_ready,
	output mrg_pkg::mrg_row_t              row,
	input  logic                           cfg_we,
	input  logic [mrg_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input  logic [mrg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mrg_pkg::*;

	mrg_cmd_t    cmd;
	mrg_status_t st;

	mrg_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.coin_valid (coin_valid),
		.coin_ready (coin_ready),
		.st         (st),
		.cmd        (cmd)
	);

	mrg_datapath #(
		.MAX_COLS (MAX_COLS)
	) u_datapath (
		.clk       (clk),
		.arst_n    (arst_n),
		.cmd       (cmd),
		.st        (st),
		.coin      (coin),
		.cfg_we    (cfg_we),
		.cfg_addr  (cfg_addr),
		.cfg_wdata (cfg_wdata),
		.row_valid (row_valid),
		.row_ready (row_ready),
		.row       (row)
	);

endmodule

// ----- rtl/mrg_checker.sv -----
// ----------------------------------------------------------------------------
// mrg_checker
// Port-level checks of the maze row generator, bound to the top level.
// ----------------------------------------------------------------------------
module mrg_checker (
	input logic                           clk,
	input logic                           arst_n,
	input logic                           coin_valid,
	input logic                           coin_ready,
	input mrg_pkg::mrg_coin_t             coin,
	input logic                           row_valid,
	input logic                           row_ready,
	input mrg_pkg::mrg_row_t              row,
	input logic                           cfg_we,
	input logic [mrg_pkg::CFG_IDX_W-1:0]  cfg_addr,
	input logic [mrg_pkg::CFG_DATA_W-1:0] cfg_wdata
);
	import mrg_pkg::*;

	// A waiting row item must hold until it is taken.
	a_row_hold: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && !row_ready |=> row_valid && $stable(row))
		else $error("row item changed while stalled");

	// One item at a time: the coin side closes right after an item is taken.
	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		coin_valid && coin_ready |=> !coin_ready)
		else $error("coin item taken while another is in flight");

	// The right border is always walled, so no row has all right walls open.
	a_right_border: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid |-> row.right_walls != '0)
		else $error("row without right border wall");

	// The last row closes the whole bottom border, starting at column zero.
	a_last_bottom: assert property (@(posedge clk) disable iff (!arst_n)
		row_valid && row.last_row |-> row.bottom_walls[0])
		else $error("last row leaves the bottom border open");

endmodule

bind maze_row_generator mrg_checker u_mrg_checker (.*);
